FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file of the stitch path checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked out of reset only
`define SPC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define SPC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/spc_pkg.sv
// Package of the stitch path checker: codes, widths and reset constants.
// No dependencies; imported by every module of the block.
package spc_pkg;

  localparam int unsigned COORD_BITS_DEF     = 21;
  localparam int unsigned CAP_COUNT_BITS_DEF = 16;

  localparam int unsigned CMD_W     = 2;
  localparam int unsigned CAT_W     = 3;
  localparam int unsigned OBJ_W     = 16;
  localparam int unsigned USER_O_W  = 4;
  localparam int unsigned THR_W     = 22;
  localparam int unsigned THR_SQ_W  = 2 * THR_W;
  localparam int unsigned MAXST_W   = 24;
  localparam int unsigned MAXF_W    = 16;
  localparam int unsigned TOTAL_W   = 25;
  localparam int unsigned NUM_CAT   = 5;
  localparam int unsigned SQ_LIM_BITS = 31;

  localparam int unsigned APB_AW = 6;
  localparam int unsigned APB_DW = 64;

  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = FIFO_AW + 1;

  localparam logic [THR_W-1:0]    THR_RST    = '1;
  localparam logic [THR_SQ_W-1:0] THR_SQ_RST = THR_SQ_W'(64'd4194303 * 64'd4194303);
  localparam logic [MAXST_W-1:0]  MAXST_RST  = '1;
  localparam logic [MAXF_W-1:0]   MAXF_RST   = '1;
  localparam logic [TOTAL_W-1:0]  TOTAL_MAX  = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_STITCH = 2'd0,
    CMD_JUMP   = 2'd1,
    CMD_OTHER  = 2'd2,
    CMD_END    = 2'd3
  } cmd_e;

  typedef enum logic [CAT_W-1:0] {
    CAT_SHORT = 3'd0,
    CAT_LONG  = 3'd1,
    CAT_HOOP  = 3'd2,
    CAT_JUMP  = 3'd3,
    CAT_MANY  = 3'd4,
    CAT_EMPTY = 3'd5
  } cat_e;

  typedef enum logic {
    SEV_WARN  = 1'b0,
    SEV_ERROR = 1'b1
  } sev_e;

  typedef enum logic [2:0] {
    REG_MIN_STITCH   = 3'd0,
    REG_MAX_STITCH   = 3'd1,
    REG_MAX_JUMP     = 3'd2,
    REG_MAX_STITCHES = 3'd3,
    REG_MAX_FINDINGS = 3'd4,
    REG_HOOP_EN      = 3'd5,
    REG_HOOP_X       = 3'd6,
    REG_HOOP_Y       = 3'd7
  } reg_e;

endpackage

FILE: rtl/spc_result_fifo.sv
// Finding queue of the stitch path checker: up to two writes and one read a cycle.
// Depends on spc_pkg.
module spc_result_fifo import spc_pkg::*; #(
  parameter int unsigned DATA_W = 63
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        wr_cnt_i,
  input  logic [DATA_W-1:0] wr_data0_i,
  input  logic [DATA_W-1:0] wr_data1_i,
  input  logic              rd_i,
  output logic [DATA_W-1:0] rd_data_o,
  output logic              rd_valid_o,
  output logic [FIFO_CW-1:0] count_o
);

  logic [DATA_W-1:0]  mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FIFO_CW-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q + FIFO_AW'(wr_cnt_i);
    rd_ptr_d = rd_ptr_q + FIFO_AW'(rd_i);
    count_d  = count_q + FIFO_CW'(wr_cnt_i) - FIFO_CW'(rd_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_cnt_i != 2'd0) begin
      mem[wr_ptr_q] <= wr_data0_i;
    end
    if (wr_cnt_i == 2'd2) begin
      mem[FIFO_AW'(wr_ptr_q + FIFO_AW'(1))] <= wr_data1_i;
    end
  end

  assign rd_data_o  = mem[rd_ptr_q];
  assign rd_valid_o = (count_q != '0);
  assign count_o    = count_q;

endmodule

FILE: rtl/stitch_path_checker_unit.sv
// Top level of the stitch path checker: config registers, check pipeline, finding queue.
// Depends on spc_pkg and spc_result_fifo.
//
// Use: machine commands enter on the s_axis channel (tuser = command, tdata = x, y,
// source id), one command per beat. Findings leave on the m_axis channel (tuser =
// severity and category, tdata = location and object id), tlast on the final finding
// of a command; a command gives zero, one or two findings.
// Path: a finding passes the input register, the squaring register and the queue write
// before it can be taken from the queue.
// Throughput: one command per cycle while the receiver keeps up; the rate is set by
// the finding queue (8 entries), which must keep room for two findings of every
// command in flight.
// Stall: when the receiver holds tready low the queue fills and s_axis_tready drops
// until room returns; nothing is lost or repeated.
// Reset: registers take their defaults, position history, counters and the queue
// are cleared; the block is ready for a command as soon as reset ends.
// Config: APB reads and writes, 64-bit data, register i at byte address 8*i, pready always high.
module stitch_path_checker_unit import spc_pkg::*; #(
  parameter int unsigned COORD_BITS     = COORD_BITS_DEF,
  parameter int unsigned CAP_COUNT_BITS = CAP_COUNT_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // config port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_AW-1:0]      paddr,
  input  logic [APB_DW-1:0]      pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready,
  // commands
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // pos_x, pos_y, source_id, zero fill
  input  logic [((2*COORD_BITS+OBJ_W+7)/8)*8-1:0] s_axis_tdata,
  // command
  input  logic [CMD_W-1:0]       s_axis_tuser,
  // findings
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // where_x, where_y, object_id, zero fill
  output logic [((2*COORD_BITS+OBJ_W+7)/8)*8-1:0] m_axis_tdata,
  // severity, category
  output logic [USER_O_W-1:0]    m_axis_tuser,
  output logic                   m_axis_tlast
);

  localparam int unsigned C    = COORD_BITS;
  localparam int unsigned TDW  = ((2*C+OBJ_W+7)/8)*8;
  localparam int unsigned DW   = C + 1;
  localparam int unsigned MW   = (DW > SQ_LIM_BITS) ? SQ_LIM_BITS : DW;
  localparam int unsigned SQW  = 2 * MW;
  localparam int unsigned DSW  = SQW + 1;
  localparam int unsigned CW   = (DSW > THR_SQ_W) ? DSW : THR_SQ_W;
  localparam int unsigned CMPW = (CAP_COUNT_BITS > MAXF_W) ? CAP_COUNT_BITS : MAXF_W;
  localparam int unsigned RW   = 2*C + OBJ_W + CAT_W + 2;
  localparam int unsigned PW   = FIFO_CW + 2;

  // ---------------- config registers ----------------
  logic [THR_W-1:0]    min_stitch_q, max_stitch_q, max_jump_q;
  logic [THR_SQ_W-1:0] min_sq_q, max_sq_q, jump_sq_q;
  logic [MAXST_W-1:0]  max_stitches_q;
  logic [MAXF_W-1:0]   max_find_q;
  logic                hoop_en_q;
  logic [2*C-1:0]      hoop_x_q, hoop_y_q;
  logic                cfg_wr;
  reg_e                cfg_idx;
  logic [THR_W-1:0]    wr_thr;
  logic [THR_SQ_W-1:0] wr_thr_sq;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_e'(paddr[5:3]);
  assign wr_thr  = pwdata[THR_W-1:0];
  assign wr_thr_sq = THR_SQ_W'(wr_thr) * THR_SQ_W'(wr_thr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_stitch_q   <= '0;
      min_sq_q       <= '0;
      max_stitch_q   <= THR_RST;
      max_sq_q       <= THR_SQ_RST;
      max_jump_q     <= THR_RST;
      jump_sq_q      <= THR_SQ_RST;
      max_stitches_q <= MAXST_RST;
      max_find_q     <= MAXF_RST;
      hoop_en_q      <= 1'b0;
      hoop_x_q       <= '0;
      hoop_y_q       <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MIN_STITCH: begin
          min_stitch_q <= wr_thr;
          min_sq_q     <= wr_thr_sq;
        end
        REG_MAX_STITCH: begin
          max_stitch_q <= wr_thr;
          max_sq_q     <= wr_thr_sq;
        end
        REG_MAX_JUMP: begin
          max_jump_q <= wr_thr;
          jump_sq_q  <= wr_thr_sq;
        end
        REG_MAX_STITCHES: max_stitches_q <= pwdata[MAXST_W-1:0];
        REG_MAX_FINDINGS: max_find_q     <= pwdata[MAXF_W-1:0];
        REG_HOOP_EN:      hoop_en_q      <= pwdata[0];
        REG_HOOP_X:       hoop_x_q       <= pwdata[2*C-1:0];
        REG_HOOP_Y:       hoop_y_q       <= pwdata[2*C-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_MIN_STITCH:   prdata = APB_DW'(min_stitch_q);
      REG_MAX_STITCH:   prdata = APB_DW'(max_stitch_q);
      REG_MAX_JUMP:     prdata = APB_DW'(max_jump_q);
      REG_MAX_STITCHES: prdata = APB_DW'(max_stitches_q);
      REG_MAX_FINDINGS: prdata = APB_DW'(max_find_q);
      REG_HOOP_EN:      prdata = APB_DW'(hoop_en_q);
      REG_HOOP_X:       prdata = APB_DW'(hoop_x_q);
      REG_HOOP_Y:       prdata = APB_DW'(hoop_y_q);
      default:          prdata = '0;
    endcase
  end

  // ---------------- input side: history, differences, hoop ----------------
  logic                in_acc;
  cmd_e                in_cmd;
  logic signed [C-1:0] in_x, in_y;
  logic [OBJ_W-1:0]    in_src;
  logic signed [C-1:0] ref_x, ref_y;
  logic signed [DW-1:0] diff_x, diff_y;
  logic [DW-1:0]       abs_x, abs_y;
  logic                huge;
  logic                in_chk, in_out, in_empty, in_many;
  logic signed [C-1:0] xmin, xmax, ymin, ymax;

  logic signed [C-1:0] last_stitch_x_q, last_stitch_y_q, last_pos_x_q, last_pos_y_q;
  logic                have_stitch_q, have_pos_q;
  logic [TOTAL_W-1:0]  stitch_total_q;

  assign in_cmd = cmd_e'(s_axis_tuser);
  assign in_x   = s_axis_tdata[C-1:0];
  assign in_y   = s_axis_tdata[2*C-1:C];
  assign in_src = s_axis_tdata[2*C+OBJ_W-1:2*C];
  assign in_acc = s_axis_tvalid & s_axis_tready;

  assign ref_x  = (in_cmd == CMD_STITCH) ? last_stitch_x_q : last_pos_x_q;
  assign ref_y  = (in_cmd == CMD_STITCH) ? last_stitch_y_q : last_pos_y_q;
  assign diff_x = {in_x[C-1], in_x} - {ref_x[C-1], ref_x};
  assign diff_y = {in_y[C-1], in_y} - {ref_y[C-1], ref_y};
  assign abs_x  = diff_x[DW-1] ? DW'(-diff_x) : DW'(diff_x);
  assign abs_y  = diff_y[DW-1] ? DW'(-diff_y) : DW'(diff_y);

  generate
    if (DW > SQ_LIM_BITS) begin : g_wide
      assign huge = (|abs_x[DW-1:SQ_LIM_BITS]) | (|abs_y[DW-1:SQ_LIM_BITS]);
    end else begin : g_narrow
      assign huge = 1'b0;
    end
  endgenerate

  assign in_chk = (in_cmd == CMD_STITCH) ? have_stitch_q :
                  (in_cmd == CMD_JUMP)   ? have_pos_q : 1'b0;

  assign xmin = hoop_x_q[C-1:0];
  assign xmax = hoop_x_q[2*C-1:C];
  assign ymin = hoop_y_q[C-1:0];
  assign ymax = hoop_y_q[2*C-1:C];
  assign in_out = hoop_en_q & ((in_x < xmin) | (in_x > xmax) | (in_y < ymin) | (in_y > ymax));

  assign in_empty = (stitch_total_q == '0);
  assign in_many  = stitch_total_q > TOTAL_W'(max_stitches_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_stitch_x_q <= '0;
      last_stitch_y_q <= '0;
      last_pos_x_q    <= '0;
      last_pos_y_q    <= '0;
      have_stitch_q   <= 1'b0;
      have_pos_q      <= 1'b0;
      stitch_total_q  <= '0;
    end else if (in_acc) begin
      if (in_cmd == CMD_END) begin
        last_stitch_x_q <= '0;
        last_stitch_y_q <= '0;
        last_pos_x_q    <= '0;
        last_pos_y_q    <= '0;
        have_stitch_q   <= 1'b0;
        have_pos_q      <= 1'b0;
        stitch_total_q  <= '0;
      end else begin
        if (in_cmd == CMD_STITCH) begin
          if (stitch_total_q != TOTAL_MAX) begin
            stitch_total_q <= stitch_total_q + TOTAL_W'(1);
          end
          last_stitch_x_q <= in_x;
          last_stitch_y_q <= in_y;
          have_stitch_q   <= 1'b1;
        end else if (in_cmd == CMD_JUMP) begin
          have_stitch_q <= 1'b0;
        end
        last_pos_x_q <= in_x;
        last_pos_y_q <= in_y;
        have_pos_q   <= 1'b1;
      end
    end
  end

  // ---------------- stage 1: input register ----------------
  logic                s1_valid_q;
  cmd_e                s1_cmd_q;
  logic signed [C-1:0] s1_x_q, s1_y_q;
  logic [OBJ_W-1:0]    s1_src_q;
  logic [MW-1:0]       s1_dx_q, s1_dy_q;
  logic                s1_huge_q, s1_chk_q, s1_out_q, s1_empty_q, s1_many_q;

  // ---------------- stage 2: squares ----------------
  logic                s2_valid_q;
  cmd_e                s2_cmd_q;
  logic signed [C-1:0] s2_x_q, s2_y_q;
  logic [OBJ_W-1:0]    s2_src_q;
  logic [SQW-1:0]      s2_sqx_q, s2_sqy_q;
  logic                s2_huge_q, s2_chk_q, s2_out_q, s2_empty_q, s2_many_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_acc;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_cmd_q   <= in_cmd;
    s1_x_q     <= in_x;
    s1_y_q     <= in_y;
    s1_src_q   <= in_src;
    s1_dx_q    <= abs_x[MW-1:0];
    s1_dy_q    <= abs_y[MW-1:0];
    s1_huge_q  <= huge;
    s1_chk_q   <= in_chk;
    s1_out_q   <= in_out;
    s1_empty_q <= in_empty;
    s1_many_q  <= in_many;

    s2_cmd_q   <= s1_cmd_q;
    s2_x_q     <= s1_x_q;
    s2_y_q     <= s1_y_q;
    s2_src_q   <= s1_src_q;
    s2_sqx_q   <= SQW'(s1_dx_q) * SQW'(s1_dx_q);
    s2_sqy_q   <= SQW'(s1_dy_q) * SQW'(s1_dy_q);
    s2_huge_q  <= s1_huge_q;
    s2_chk_q   <= s1_chk_q;
    s2_out_q   <= s1_out_q;
    s2_empty_q <= s1_empty_q;
    s2_many_q  <= s1_many_q;
  end

  // ---------------- stage 3: compare, cap, build findings ----------------
  logic [CAP_COUNT_BITS-1:0] cnt_q [NUM_CAT];
  logic [CW-1:0]       d_sum;
  logic                lt_min, gt_max, gt_jump;
  logic [NUM_CAT-1:0]  hit, adm, emit;
  logic                is_stitch, is_jump, is_end, emit_empty, len_emit;
  cat_e                len_cat;
  logic [1:0]          n_res;
  logic [RW-1:0]       res0, res1;

  assign d_sum   = CW'(s2_sqx_q) + CW'(s2_sqy_q);
  assign lt_min  = !s2_huge_q && (d_sum < CW'(min_sq_q));
  assign gt_max  = s2_huge_q || (d_sum > CW'(max_sq_q));
  assign gt_jump = s2_huge_q || (d_sum > CW'(jump_sq_q));

  assign is_stitch = s2_valid_q && (s2_cmd_q == CMD_STITCH);
  assign is_jump   = s2_valid_q && (s2_cmd_q == CMD_JUMP);
  assign is_end    = s2_valid_q && (s2_cmd_q == CMD_END);

  always_comb begin
    hit = '0;
    hit[CAT_SHORT] = is_stitch & s2_chk_q & lt_min;
    hit[CAT_LONG]  = is_stitch & s2_chk_q & !lt_min & gt_max;
    hit[CAT_HOOP]  = is_stitch & s2_out_q;
    hit[CAT_JUMP]  = is_jump & s2_chk_q & gt_jump;
    hit[CAT_MANY]  = is_end & !s2_empty_q & s2_many_q;
    for (int k = 0; k < NUM_CAT; k++) begin
      adm[k] = CMPW'(cnt_q[k]) < CMPW'(max_find_q);
    end
  end

  assign emit       = hit & adm;
  assign emit_empty = is_end & s2_empty_q;
  assign len_emit   = emit[CAT_SHORT] | emit[CAT_LONG];
  assign len_cat    = emit[CAT_SHORT] ? CAT_SHORT : CAT_LONG;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_CAT; k++) begin
        cnt_q[k] <= '0;
      end
    end else begin
      for (int k = 0; k < NUM_CAT; k++) begin
        if (is_end) begin
          cnt_q[k] <= '0;
        end else if (hit[k] && !(&cnt_q[k])) begin
          cnt_q[k] <= cnt_q[k] + CAP_COUNT_BITS'(1);
        end
      end
    end
  end

  // entry layout, low to high: x, y, object id, severity, category, last
  always_comb begin
    n_res = 2'd0;
    res0  = '0;
    res1  = '0;
    if (is_stitch) begin
      n_res = 2'(len_emit) + 2'(emit[CAT_HOOP]);
      if (len_emit) begin
        res0 = {1'b0, len_cat, SEV_WARN, s2_src_q, s2_y_q, s2_x_q};
      end else begin
        res0 = {1'b0, CAT_HOOP, SEV_ERROR, s2_src_q, s2_y_q, s2_x_q};
      end
      res1 = {1'b1, CAT_HOOP, SEV_ERROR, s2_src_q, s2_y_q, s2_x_q};
    end else if (is_jump) begin
      n_res = 2'(emit[CAT_JUMP]);
      res0  = {1'b0, CAT_JUMP, SEV_WARN, s2_src_q, s2_y_q, s2_x_q};
    end else if (is_end) begin
      n_res = 2'(emit_empty | emit[CAT_MANY]);
      if (emit_empty) begin
        res0 = {1'b0, CAT_EMPTY, SEV_ERROR, {(RW-CAT_W-2){1'b0}}};
      end else begin
        res0 = {1'b0, CAT_MANY, SEV_WARN, {(RW-CAT_W-2){1'b0}}};
      end
    end
    res0[RW-1] = (n_res == 2'd1);
  end

  // ---------------- finding queue ----------------
  logic [RW-1:0]      q_data;
  logic               q_valid, q_pop;
  logic [FIFO_CW-1:0] q_count;
  logic [PW-1:0]      pending;

  assign q_pop = m_axis_tvalid & m_axis_tready;

  spc_result_fifo #(
    .DATA_W (RW)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_cnt_i   (n_res),
    .wr_data0_i (res0),
    .wr_data1_i (res1),
    .rd_i       (q_pop),
    .rd_data_o  (q_data),
    .rd_valid_o (q_valid),
    .count_o    (q_count)
  );

  // every command in flight may still add two findings
  assign pending = PW'(q_count) - PW'(q_pop) + PW'({s1_valid_q, 1'b0}) + PW'({s2_valid_q, 1'b0});
  assign s_axis_tready = (pending <= PW'(FIFO_DEPTH - 2));

  assign m_axis_tvalid = q_valid;
  assign m_axis_tdata  = TDW'(q_data[2*C+OBJ_W-1:0]);
  assign m_axis_tuser  = {q_data[RW-2:RW-1-CAT_W], q_data[2*C+OBJ_W]};
  assign m_axis_tlast  = q_data[RW-1];

endmodule

FILE: rtl/spc_checker.sv
// Port-level assertions of the stitch path checker, bound to its top level.
// Depends on spc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module spc_checker import spc_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [((2*COORD_BITS+OBJ_W+7)/8)*8-1:0] m_axis_tdata,
  input logic [USER_O_W-1:0]    m_axis_tuser,
  input logic                   m_axis_tlast
);

  localparam int unsigned TDW = ((2*COORD_BITS+OBJ_W+7)/8)*8;

  logic [CAT_W-1:0]      cat;
  logic                  sev;
  logic                  sev_want, cat_ok, pat_lvl, stalled;
  logic [TDW+USER_O_W:0] beat;

  assign sev      = m_axis_tuser[0];
  assign cat      = m_axis_tuser[CAT_W:1];
  assign pat_lvl  = (cat == CAT_MANY) || (cat == CAT_EMPTY);
  assign cat_ok   = (cat == CAT_SHORT) || (cat == CAT_LONG) || (cat == CAT_HOOP) ||
                    (cat == CAT_JUMP) || pat_lvl;
  assign sev_want = (cat == CAT_HOOP) || (cat == CAT_EMPTY);
  assign stalled  = m_axis_tvalid & !m_axis_tready;
  assign beat     = {m_axis_tlast, m_axis_tuser, m_axis_tdata};

  // an edge in reset leaves the queue empty for the next edge
  `SPC_ASSERT_ALWAYS(a_no_beat_in_reset, clk_i, !rst_ni |=> !m_axis_tvalid, "finding in reset")

  `SPC_ASSERT(a_stall_hold, clk_i, rst_ni, stalled |=> m_axis_tvalid && $stable(beat), "stall broken")

  `SPC_ASSERT(a_cat_known, clk_i, rst_ni, m_axis_tvalid |-> cat_ok, "bad category")

  `SPC_ASSERT(a_sev_match, clk_i, rst_ni, m_axis_tvalid |-> sev == sev_want, "severity mismatch")

  `SPC_ASSERT(a_pattern_level, clk_i, rst_ni, m_axis_tvalid && pat_lvl |-> m_axis_tdata == '0 && m_axis_tlast, "bare")

endmodule

bind stitch_path_checker_unit spc_checker #(
  .COORD_BITS (COORD_BITS)
) u_spc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

FILE: tb/tb_top.sv
// Self-checking bench for stitch_path_checker_unit: streams machine commands, predicts findings.
// Depends on spc_pkg and the RTL of the block; writes registers over the APB port.
`timescale 1ns / 100ps

module tb_top;
  import spc_pkg::*;

  localparam int unsigned CB          = COORD_BITS_DEF;
  localparam int unsigned TDATA_W     = ((2*CB+OBJ_W+7)/8)*8;
  localparam int unsigned PIPE_SLACK  = 8;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned MAX_REPORTS = 10;
  localparam longint     TIMEOUT_NS   = 5_000_000;

  typedef struct packed {
    sev_e                    sev;
    cat_e                    cat;
    logic signed [CB-1:0]    x;
    logic signed [CB-1:0]    y;
    logic [OBJ_W-1:0]        obj;
    logic                    last;
  } finding_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [TDATA_W-1:0] s_axis_tdata = '0;   // pos_x, pos_y, source_id, zero fill
  logic [CMD_W-1:0] s_axis_tuser = '0;     // command
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;        // where_x, where_y, object_id, zero fill
  logic [USER_O_W-1:0] m_axis_tuser;       // severity, category
  logic m_axis_tlast;

  // register copies
  logic [THR_W-1:0]   cfg_min_stitch = '0;
  logic [THR_W-1:0]   cfg_max_stitch = THR_RST;
  logic [THR_W-1:0]   cfg_max_jump = THR_RST;
  logic [MAXST_W-1:0] cfg_max_stitches = MAXST_RST;
  logic [MAXF_W-1:0]  cfg_max_findings = MAXF_RST;
  logic               cfg_hoop_en = 1'b0;
  logic [2*CB-1:0]    cfg_hoop_x = '0;
  logic [2*CB-1:0]    cfg_hoop_y = '0;

  // pattern state of the predictor
  logic signed [CB-1:0] stitch_x = '0, stitch_y = '0, pos_x = '0, pos_y = '0;
  logic have_stitch = 1'b0, have_pos = 1'b0;
  logic [CAP_COUNT_BITS_DEF-1:0] cat_counts [NUM_CAT] = '{default: '0};
  logic [TOTAL_W-1:0] stitch_total = '0;

  finding_t findings_due [$];
  int mismatches = 0;
  int findings_seen = 0;
  int commands_sent = 0;
  int settings_applied = 0;
  int hold_kick = 0, hold_seen = 0, hold_left = 0, stall_left = 0;
  bit tx_idle_en = 1'b1, rx_idle_en = 1'b1;

  stitch_path_checker_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint unsigned sq_dist(longint ax, longint ay, longint bx, longint by);
    longint unsigned dx, dy;
    dx = (ax >= bx) ? ax - bx : bx - ax;
    dy = (ay >= by) ? ay - by : by - ay;
    if (dx >= (64'd1 << SQ_LIM_BITS) || dy >= (64'd1 << SQ_LIM_BITS)) return '1;
    return dx * dx + dy * dy;
  endfunction

  function automatic bit admit(cat_e c);
    bit ok;
    ok = cat_counts[c] < cfg_max_findings;
    if (cat_counts[c] != '1) cat_counts[c] = cat_counts[c] + 1'b1;
    return ok;
  endfunction

  function automatic finding_t make_finding(sev_e s, cat_e c, logic signed [CB-1:0] x,
                                            logic signed [CB-1:0] y, logic [OBJ_W-1:0] o);
    finding_t f;
    f.sev = s;
    f.cat = c;
    f.x = x;
    f.y = y;
    f.obj = o;
    f.last = 1'b0;
    return f;
  endfunction

  function automatic void queue_finding(finding_t f);
    findings_due = {findings_due, f};
  endfunction

  task automatic predict_findings(cmd_e c, logic signed [CB-1:0] px, logic signed [CB-1:0] py,
                                  logic [OBJ_W-1:0] src);
    int unsigned base;
    longint unsigned d, lim;
    logic signed [CB-1:0] xmin, xmax, ymin, ymax;
    base = findings_due.size();
    if (c == CMD_END) begin
      if (stitch_total == '0)
        queue_finding(make_finding(SEV_ERROR, CAT_EMPTY, '0, '0, '0));
      else if (stitch_total > cfg_max_stitches && admit(CAT_MANY))
        queue_finding(make_finding(SEV_WARN, CAT_MANY, '0, '0, '0));
      stitch_x = '0;
      stitch_y = '0;
      pos_x = '0;
      pos_y = '0;
      have_stitch = 1'b0;
      have_pos = 1'b0;
      foreach (cat_counts[k]) cat_counts[k] = '0;
      stitch_total = '0;
    end else begin
      if (c == CMD_STITCH) begin
        if (stitch_total != TOTAL_MAX) stitch_total = stitch_total + 1'b1;
        if (have_stitch) begin
          d = sq_dist(px, py, stitch_x, stitch_y);
          lim = cfg_min_stitch;
          lim = lim * lim;
          if (d < lim) begin
            if (admit(CAT_SHORT)) queue_finding(make_finding(SEV_WARN, CAT_SHORT, px, py, src));
          end else begin
            lim = cfg_max_stitch;
            lim = lim * lim;
            if (d > lim && admit(CAT_LONG))
              queue_finding(make_finding(SEV_WARN, CAT_LONG, px, py, src));
          end
        end
        if (cfg_hoop_en) begin
          xmin = cfg_hoop_x[CB-1:0];
          xmax = cfg_hoop_x[2*CB-1:CB];
          ymin = cfg_hoop_y[CB-1:0];
          ymax = cfg_hoop_y[2*CB-1:CB];
          if ((px < xmin || px > xmax || py < ymin || py > ymax) && admit(CAT_HOOP))
            queue_finding(make_finding(SEV_ERROR, CAT_HOOP, px, py, src));
        end
        stitch_x = px;
        stitch_y = py;
        have_stitch = 1'b1;
      end else if (c == CMD_JUMP) begin
        if (have_pos) begin
          d = sq_dist(px, py, pos_x, pos_y);
          lim = cfg_max_jump;
          lim = lim * lim;
          if (d > lim && admit(CAT_JUMP))
            queue_finding(make_finding(SEV_WARN, CAT_JUMP, px, py, src));
        end
        have_stitch = 1'b0;
      end
      pos_x = px;
      pos_y = py;
      have_pos = 1'b1;
    end
    if (findings_due.size() > base) findings_due[findings_due.size()-1].last = 1'b1;
  endtask

  task automatic flag_mismatch(string what, longint want_v, longint got_v);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch on %s at finding %0d: expected %0d, got %0d",
               what, findings_seen, want_v, got_v);
  endtask

  task automatic check_finding();
    finding_t want;
    findings_seen++;
    if (findings_due.size() == 0) begin
      flag_mismatch("finding with none due, category", -1, m_axis_tuser[3:1]);
      return;
    end
    want = findings_due.pop_front();
    if (m_axis_tuser[0] !== want.sev) flag_mismatch("severity", want.sev, m_axis_tuser[0]);
    if (m_axis_tuser[3:1] !== want.cat) flag_mismatch("category", want.cat, m_axis_tuser[3:1]);
    if (m_axis_tdata[CB-1:0] !== want.x)
      flag_mismatch("where_x", want.x, $signed(m_axis_tdata[CB-1:0]));
    if (m_axis_tdata[2*CB-1:CB] !== want.y)
      flag_mismatch("where_y", want.y, $signed(m_axis_tdata[2*CB-1:CB]));
    if (m_axis_tdata[2*CB+OBJ_W-1:2*CB] !== want.obj)
      flag_mismatch("object_id", want.obj, m_axis_tdata[2*CB+OBJ_W-1:2*CB]);
    if (m_axis_tlast !== want.last) flag_mismatch("tlast", want.last, m_axis_tlast);
  endtask

  // command monitor feeds the predictor
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      predict_findings(cmd_e'(s_axis_tuser), s_axis_tdata[CB-1:0], s_axis_tdata[2*CB-1:CB],
                       s_axis_tdata[2*CB+OBJ_W-1:2*CB]);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_finding();
  end

  // finding receiver: short random stalls, plus a long hold on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_seen != hold_kick) begin
      hold_seen <= hold_kick;
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 3);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  function automatic logic [APB_DW-1:0] shadow_value(reg_e r);
    case (r)
      REG_MIN_STITCH:   return APB_DW'(cfg_min_stitch);
      REG_MAX_STITCH:   return APB_DW'(cfg_max_stitch);
      REG_MAX_JUMP:     return APB_DW'(cfg_max_jump);
      REG_MAX_STITCHES: return APB_DW'(cfg_max_stitches);
      REG_MAX_FINDINGS: return APB_DW'(cfg_max_findings);
      REG_HOOP_EN:      return APB_DW'(cfg_hoop_en);
      REG_HOOP_X:       return APB_DW'(cfg_hoop_x);
      default:          return APB_DW'(cfg_hoop_y);
    endcase
  endfunction

  task automatic check_reg(reg_e r);
    logic [APB_DW-1:0] got;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= APB_AW'({r, 3'b000});
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (got !== shadow_value(r)) flag_mismatch({"register ", r.name()}, shadow_value(r), got);
    @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e r, logic [APB_DW-1:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_AW'({r, 3'b000});
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    case (r)
      REG_MIN_STITCH:   cfg_min_stitch = v[THR_W-1:0];
      REG_MAX_STITCH:   cfg_max_stitch = v[THR_W-1:0];
      REG_MAX_JUMP:     cfg_max_jump = v[THR_W-1:0];
      REG_MAX_STITCHES: cfg_max_stitches = v[MAXST_W-1:0];
      REG_MAX_FINDINGS: cfg_max_findings = v[MAXF_W-1:0];
      REG_HOOP_EN:      cfg_hoop_en = v[0];
      REG_HOOP_X:       cfg_hoop_x = v[2*CB-1:0];
      default:          cfg_hoop_y = v[2*CB-1:0];
    endcase
    @(posedge clk_i);
    check_reg(r);
  endtask

  // sender stops, every finding drains, pipeline empties
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (findings_due.size() != 0);
    repeat (PIPE_SLACK) @(posedge clk_i);
  endtask

  function automatic logic [2*CB-1:0] hoop_box(int lo, int hi);
    return {CB'(hi), CB'(lo)};
  endfunction

  task automatic apply_settings(logic [THR_W-1:0] mn, logic [THR_W-1:0] mx,
                                logic [THR_W-1:0] jp, logic [MAXST_W-1:0] ms,
                                logic [MAXF_W-1:0] mf, logic en,
                                logic [2*CB-1:0] hx, logic [2*CB-1:0] hy);
    settle();
    write_reg(REG_MIN_STITCH, APB_DW'(mn));
    write_reg(REG_MAX_STITCH, APB_DW'(mx));
    write_reg(REG_MAX_JUMP, APB_DW'(jp));
    write_reg(REG_MAX_STITCHES, APB_DW'(ms));
    write_reg(REG_MAX_FINDINGS, APB_DW'(mf));
    write_reg(REG_HOOP_EN, APB_DW'(en));
    write_reg(REG_HOOP_X, APB_DW'(hx));
    write_reg(REG_HOOP_Y, APB_DW'(hy));
    settings_applied++;
  endtask

  task automatic send_cmd(cmd_e c, int x, int y, logic [OBJ_W-1:0] src);
    s_axis_tuser <= c;
    s_axis_tdata <= TDATA_W'({src, CB'(y), CB'(x)});
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    commands_sent++;
    if (tx_idle_en && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  function automatic int rand_offset(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic longint pick_value(longint lo, longint hi, longint top);
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 0;
    if (r == 1) return top;
    return $urandom_range(lo, hi);
  endfunction

  // one pattern: a run of stitches with jumps, other commands and some noise, then mostly an end
  task automatic run_pattern();
    int x, y, len, span, kind, i;
    x = rand_offset(150000);
    y = rand_offset(150000);
    case ($urandom_range(0, 2))
      0:       span = 400;
      1:       span = 4000;
      default: span = 40000;
    endcase
    kind = $urandom_range(0, 9);
    if (kind == 1) begin
      repeat ($urandom_range(1, 6))
        send_cmd(cmd_e'($urandom_range(0, 3)), $urandom, $urandom, OBJ_W'($urandom));
      return;
    end
    len = (kind == 0) ? 0 : $urandom_range(1, 30);
    for (i = 0; i < len; i++) begin
      case ($urandom_range(0, 15))
        0: begin
          x += rand_offset(span * 8);
          y += rand_offset(span * 8);
          send_cmd(CMD_JUMP, x, y, OBJ_W'($urandom));
        end
        1: send_cmd(CMD_OTHER, x + rand_offset(span), y + rand_offset(span), OBJ_W'($urandom));
        2: send_cmd(cmd_e'($urandom_range(0, 3)), $urandom, $urandom, OBJ_W'($urandom));
        default: begin
          if ($urandom_range(0, 15) != 0) begin
            x += rand_offset(span);
            y += rand_offset(span);
          end
          send_cmd(CMD_STITCH, x, y, OBJ_W'($urandom));
        end
      endcase
    end
    send_cmd(CMD_END, $urandom, $urandom, OBJ_W'($urandom));
  endtask

  task automatic run_patterns(int budget);
    int start;
    start = commands_sent;
    while (commands_sent - start < budget) run_pattern();
  endtask

  task automatic apply_random_settings();
    int lo_x, hi_x, lo_y, hi_y, t;
    lo_x = -int'($urandom_range(0, 150000));
    hi_x = $urandom_range(0, 150000);
    lo_y = -int'($urandom_range(0, 150000));
    hi_y = $urandom_range(0, 150000);
    if ($urandom_range(0, 7) == 0) begin
      t = lo_x;
      lo_x = hi_x;
      hi_x = t;
    end
    if ($urandom_range(0, 9) == 0) begin
      lo_y = -(1 << (CB - 1));
      hi_y = (1 << (CB - 1)) - 1;
    end
    apply_settings(THR_W'(pick_value(0, 3000, THR_RST)),
                   THR_W'(pick_value(2000, 40000, THR_RST)),
                   THR_W'(pick_value(5000, 200000, THR_RST)),
                   MAXST_W'(pick_value(1, 40, MAXST_RST)),
                   MAXF_W'(pick_value(1, 6, MAXF_RST)), 1'($urandom_range(0, 1)),
                   hoop_box(lo_x, hi_x), hoop_box(lo_y, hi_y));
  endtask

  task automatic test_reset_values();
    reg_e r;
    r = r.first();
    do begin
      check_reg(r);
      r = r.next();
    end while (r != r.first());
  endtask

  // boundaries of every check, result ordering, empty and too-many ends
  task automatic test_directed_checks();
    apply_settings(1000, 5000, 8000, 3, MAXF_RST, 1'b1,
                   hoop_box(-5000, 5000), hoop_box(-5000, 5000));
    send_cmd(CMD_END, 0, 0, 16'h0000);
    send_cmd(CMD_STITCH, 0, 0, 16'h0001);
    send_cmd(CMD_STITCH, 1000, 0, 16'h0002);       // exactly minimum length
    send_cmd(CMD_STITCH, 1010, 10, 16'h0003);      // short
    send_cmd(CMD_STITCH, 1010, 5010, 16'h0004);    // exactly maximum, outside hoop
    send_cmd(CMD_STITCH, 1010, -1000, 16'h0005);   // long
    send_cmd(CMD_STITCH, 6000, -1000, 16'h0006);   // outside hoop
    send_cmd(CMD_STITCH, 6000, -1001, 16'h0007);   // short then hoop
    send_cmd(CMD_JUMP, 14000, -1001, 16'h0008);    // jump of exactly the limit
    send_cmd(CMD_JUMP, 22001, -1001, 16'h0009);
    send_cmd(CMD_OTHER, 0, 0, 16'h000A);
    send_cmd(CMD_STITCH, -5000, 5000, 16'h000B);   // continuity broken, on hoop edge
    send_cmd(CMD_STITCH, -5001, 5000, 16'h000C);
    send_cmd(CMD_END, 1, 1, 16'h1234);             // too many stitches
    send_cmd(CMD_JUMP, 0, 0, 16'h000D);
    send_cmd(CMD_JUMP, -(1 << (CB - 1)), -(1 << (CB - 1)), 16'h000E);
    send_cmd(CMD_JUMP, (1 << (CB - 1)) - 1, (1 << (CB - 1)) - 1, 16'h000F);
    send_cmd(CMD_END, 0, 0, 16'h0000);             // empty, jump findings already out
    send_cmd(CMD_STITCH, (1 << (CB - 1)) - 1, -(1 << (CB - 1)), 16'hFFFF);
    send_cmd(CMD_STITCH, -(1 << (CB - 1)), (1 << (CB - 1)) - 1, 16'h0000);
    send_cmd(CMD_END, 0, 0, 16'h0000);
    apply_settings(1000, 5000, 8000, 3, MAXF_RST, 1'b1,
                   hoop_box(100, -100), hoop_box(-5000, 5000));
    send_cmd(CMD_STITCH, 0, 0, 16'h0010);          // inverted box: always outside
    send_cmd(CMD_END, 0, 0, 16'h0000);
  endtask

  task automatic test_capping();
    apply_settings(0, 0, 0, 0, 2, 1'b1, hoop_box(-20000, 20000), hoop_box(-20000, 20000));
    run_patterns(100);
    apply_settings(500, 3000, 10000, 5, 0, 1'b1, hoop_box(-50000, 50000), hoop_box(-50000, 50000));
    run_patterns(100);
    apply_settings(2000, 2500, 4000, 1, 1, 1'b1, hoop_box(-8000, 8000), hoop_box(-8000, 8000));
    run_patterns(100);
  endtask

  task automatic test_extreme_settings();
    apply_settings('0, '0, '0, '0, MAXF_RST, 1'b1,
                   hoop_box(-(1 << (CB - 1)), (1 << (CB - 1)) - 1),
                   hoop_box(-(1 << (CB - 1)), (1 << (CB - 1)) - 1));
    run_patterns(100);
    apply_settings(THR_RST, THR_RST, THR_RST, MAXST_RST, MAXF_RST, 1'b1,
                   hoop_box(0, 0), hoop_box(0, 0));
    run_patterns(100);
  endtask

  task automatic test_back_pressure();
    int i;
    apply_settings(0, 0, 0, 0, MAXF_RST, 1'b1, hoop_box(-10, 10), hoop_box(-10, 10));
    tx_idle_en <= 1'b0;
    hold_kick <= hold_kick + 1;
    for (i = 0; i < 40; i++)
      send_cmd(CMD_STITCH, rand_offset(5000), rand_offset(5000), OBJ_W'($urandom));
    settle();
    tx_idle_en <= 1'b1;
    hold_kick <= hold_kick + 1;
    run_patterns(60);
  endtask

  task automatic test_random_sweep();
    repeat (8) begin
      apply_random_settings();
      tx_idle_en <= ($urandom_range(0, 3) != 0);
      rx_idle_en <= ($urandom_range(0, 3) != 0);
      run_patterns(120);
    end
  endtask

  task automatic test_steady_stream();
    apply_random_settings();
    tx_idle_en <= 1'b0;
    rx_idle_en <= 1'b0;
    run_patterns(150);
  endtask

  initial begin
    int waited;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_directed_checks();
    test_capping();
    test_extreme_settings();
    test_back_pressure();
    test_random_sweep();
    test_steady_stream();
    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (findings_due.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (PIPE_SLACK) @(posedge clk_i);
    $display("run covered %0d commands and %0d findings under %0d register settings",
             commands_sent, findings_seen, settings_applied);
    $display("directed edges, finding caps, extreme registers, a long hold and random patterns");
    if (findings_due.size() != 0) $display("%0d findings never arrived", findings_due.size());
    if (mismatches == 0 && findings_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timed out");
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
